// ===== src/lbm_pkg.sv =====
// Package for the D2Q9 BGK collision block: field widths, register indexes,
// lattice codes and a saturation helper. No dependencies.
package lbm_pkg;

	localparam int DATA_W = 32;
	localparam int NUM_DIRS_MAX = 9;
	localparam int CFG_W = 31;
	localparam int CNT_W = 17;

	typedef enum logic [2:0] {
		REG_INV_TAU = 3'd0,
		REG_DIR_X = 3'd1,
		REG_DIR_Y = 3'd2,
		REG_WCLASS = 3'd3,
		REG_W_REST = 3'd4,
		REG_W_AXIS = 3'd5,
		REG_W_DIAG = 3'd6,
		REG_NODE_CNT = 3'd7
	} reg_idx_t;

	localparam logic [1:0] COMP_POS = 2'd1;
	localparam logic [1:0] COMP_NEG = 2'd3;
	localparam logic [1:0] WCLS_REST = 2'd0;
	localparam logic [1:0] WCLS_AXIS = 2'd1;
	localparam logic [1:0] WCLS_DIAG = 2'd2;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		logic [1:0] ex;
		logic [1:0] ey;
		logic [CFG_W-1:0] w;
	} lane_cfg_t;

	function automatic word_t sat_w(input logic signed [95:0] v);
		logic signed [95:0] hi;
		logic signed [95:0] lo;
		begin
			hi = 96'sh7FFFFFFF;
			lo = -96'sh80000000;
			if (v > hi) sat_w = 32'sh7FFFFFFF;
			else if (v < lo) sat_w = 32'sh80000000;
			else sat_w = v[DATA_W-1:0];
		end
	endfunction

endpackage

// ===== src/lbm_if.sv =====
// Valid/ready channel carrying one packed payload.
// Depends on nothing.
interface lbm_if #(parameter int W = 32);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== src/lbm_lane.sv =====
// One direction of the collision pipeline, six stages, advance when en.
// Depends on lbm_pkg.
module lbm_lane import lbm_pkg::*; #(
	parameter int FRAC_BITS = 28
) (
	input logic clk,
	input logic en,
	input lane_cfg_t cfg,
	input logic [CFG_W-1:0] inv_tau,
	input word_t rho,
	input word_t ux,
	input word_t uy,
	input word_t usq_s1,
	input word_t f,
	output word_t post
);
	word_t eu_s1, rho_s1, f_s1, wr_s2, poly_s3, wr_s3, f_s2, f_s3;
	word_t eu_s2, usq_s2, eu2_s2, feq_s4, f_s4, f_s5;
	logic [CFG_W-1:0] w_s1;
	logic signed [33:0] eux, euy;
	logic signed [95:0] eu2p, wrp, polyv, feqp, relp;
	logic signed [34:0] diff_c;
	logic signed [34:0] diff_s5;
	logic signed [95:0] rel_s6;
	word_t f_s6;

	always_comb begin
		case (cfg.ex)
			COMP_POS: eux = 34'(ux);
			COMP_NEG: eux = -34'(ux);
			default: eux = '0;
		endcase
		case (cfg.ey)
			COMP_POS: euy = 34'(uy);
			COMP_NEG: euy = -34'(uy);
			default: euy = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eu_s1 <= sat_w(96'(eux + euy));
			rho_s1 <= rho; f_s1 <= f; w_s1 <= cfg.w;
		end
	end

	assign eu2p = (96'(eu_s1) * 96'(eu_s1)) >>> FRAC_BITS;
	assign wrp = (96'(signed'({1'b0, w_s1})) * 96'(rho_s1)) >>> FRAC_BITS;
	always_ff @(posedge clk) begin
		if (en) begin
			eu2_s2 <= sat_w(eu2p); wr_s2 <= sat_w(wrp);
			eu_s2 <= eu_s1; usq_s2 <= usq_s1; f_s2 <= f_s1;
		end
	end

	assign polyv = (96'sd1 <<< FRAC_BITS) + 96'sd3 * 96'(eu_s2)
		+ ((96'sd9 * 96'(eu2_s2)) >>> 1) - ((96'sd3 * 96'(usq_s2)) >>> 1);
	always_ff @(posedge clk) begin
		if (en) begin
			poly_s3 <= sat_w(polyv); wr_s3 <= wr_s2; f_s3 <= f_s2;
		end
	end

	assign feqp = (96'(wr_s3) * 96'(poly_s3)) >>> FRAC_BITS;
	always_ff @(posedge clk) begin
		if (en) begin
			feq_s4 <= sat_w(feqp); f_s4 <= f_s3;
		end
	end

	assign diff_c = 35'(feq_s4) - 35'(f_s4);
	always_ff @(posedge clk) begin
		if (en) begin
			diff_s5 <= diff_c; f_s5 <= f_s4;
		end
	end

	assign relp = (96'(signed'({1'b0, inv_tau})) * 96'(diff_s5)) >>> FRAC_BITS;
	always_ff @(posedge clk) begin
		if (en) begin
			rel_s6 <= relp; f_s6 <= f_s5;
		end
	end

	assign post = sat_w(96'(f_s6) + rel_s6);
endmodule

// ===== src/lbm_merge.sv =====
// Output stage: registers the merged lane results and chunk flag as one
// transfer with a skid slot. Depends on lbm_pkg, lbm_if.
module lbm_merge import lbm_pkg::*; #(
	parameter int W = 289
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [W-1:0] in_data,
	output logic in_ready,
	lbm_if.source out_ch
);
	logic [W-1:0] skid_q;
	logic skid_vld_q;
	logic out_vld_q;
	logic [W-1:0] out_q;

	assign in_ready = !skid_vld_q;
	assign out_ch.valid = out_vld_q;
	assign out_ch.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || out_ch.ready) begin
				if (skid_vld_q) begin
					out_vld_q <= 1'b1; out_q <= skid_q; skid_vld_q <= 1'b0;
				end else begin
					out_vld_q <= in_valid; out_q <= in_data;
				end
			end else if (in_valid && !skid_vld_q) begin
				skid_vld_q <= 1'b1; skid_q <= in_data;
			end
		end
	end
endmodule

// ===== src/lbm_d2q9_bgk_collision.sv =====
// Top level of the D2Q9 BGK collision block: config registers, lanes, merge.
// Depends on lbm_pkg, lbm_if, lbm_lane, lbm_merge.
//  channel | dir | payload
//  in_ch   | in  | rho, ux, uy, dist_0..8 (12 x 32 bits)
//  out_ch  | out | post_0..8, chunk_end (289 bits)
//  cfg     | in  | cfg_we, cfg_index[2:0], cfg_data[30:0]
// One node per cycle while the merge stage has room; the result reaches
// out_ch through the six lane stages and the output register.
// Pipeline advances whenever the merge stage has room; in_ch.ready
// drops only while its skid slot is full. Reset clears valids and counter.
module lbm_d2q9_bgk_collision import lbm_pkg::*; #(
	parameter int DIRECTIONS = 9,
	parameter int FRAC_BITS = 28
) (
	input logic clk,
	input logic arst_n,
	lbm_if.sink in_ch,
	lbm_if.source out_ch,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);
	localparam int LAT = 6;
	localparam int OW = NUM_DIRS_MAX*DATA_W + 1;

	logic [CFG_W-1:0] inv_tau_q, wr_q, wa_q, wd_q;
	logic [17:0] dx_q, dy_q, wc_q;
	logic [CNT_W-1:0] ncnt_q, node_counter_q;
	logic [LAT-1:0] vld_q, end_q;
	logic en, mrg_ready, endc;
	word_t rho, ux, uy, usq_s1;
	logic signed [95:0] usqp;
	logic [OW-1:0] mdata;
	word_t posts [NUM_DIRS_MAX];
	logic [CNT_W-1:0] cnt, nxt;

	assign rho = in_ch.data[DATA_W-1:0];
	assign ux = in_ch.data[2*DATA_W-1:DATA_W];
	assign uy = in_ch.data[3*DATA_W-1:2*DATA_W];
	assign en = mrg_ready;
	assign in_ch.ready = mrg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_tau_q <= 31'd268435456; dx_q <= 18'd128196; dy_q <= 18'd251664;
			wc_q <= 18'd174420; wr_q <= 31'd119304647; wa_q <= 31'd29826162;
			wd_q <= 31'd7456540; ncnt_q <= 17'd1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_INV_TAU: inv_tau_q <= cfg_data;
				REG_DIR_X: dx_q <= cfg_data[17:0];
				REG_DIR_Y: dy_q <= cfg_data[17:0];
				REG_WCLASS: wc_q <= cfg_data[17:0];
				REG_W_REST: wr_q <= cfg_data;
				REG_W_AXIS: wa_q <= cfg_data;
				REG_W_DIAG: wd_q <= cfg_data;
				REG_NODE_CNT: ncnt_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cnt = (ncnt_q == '0) ? CNT_W'(1) : ncnt_q;
	assign nxt = node_counter_q + CNT_W'(1);
	assign endc = nxt >= cnt;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_counter_q <= '0; vld_q <= '0; end_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
			end_q <= {end_q[LAT-2:0], endc};
			if (in_ch.valid) node_counter_q <= endc ? '0 : nxt;
		end
	end

	assign usqp = (96'(ux)*96'(ux) + 96'(uy)*96'(uy)) >>> FRAC_BITS;
	always_ff @(posedge clk) begin
		if (en) usq_s1 <= sat_w(usqp);
	end

	for (genvar l = 0; l < NUM_DIRS_MAX; l++) begin : g_lane
		if (l < DIRECTIONS) begin : g_on
			lane_cfg_t lc;
			always_comb begin
				lc.ex = dx_q[2*l +: 2];
				lc.ey = dy_q[2*l +: 2];
				case (wc_q[2*l +: 2])
					WCLS_REST: lc.w = wr_q;
					WCLS_AXIS: lc.w = wa_q;
					WCLS_DIAG: lc.w = wd_q;
					default: lc.w = '0;
				endcase
			end
			lbm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
				.clk(clk), .en(en), .cfg(lc), .inv_tau(inv_tau_q),
				.rho(rho), .ux(ux), .uy(uy), .usq_s1(usq_s1),
				.f(in_ch.data[(3+l)*DATA_W +: DATA_W]), .post(posts[l])
			);
		end else begin : g_off
			assign posts[l] = '0;
		end
		assign mdata[l*DATA_W +: DATA_W] = posts[l];
	end
	assign mdata[OW-1] = end_q[LAT-1];

	lbm_merge #(.W(OW)) u_merge (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_q[LAT-1]), .in_data(mdata),
		.in_ready(mrg_ready), .out_ch(out_ch)
	);
endmodule
